/* rtl/tgt_pkg.sv */
// Shared types and constants for the triangle grid tessellator.
`timescale 1ns / 1ps
`default_nettype none

package tgt_pkg;

    localparam int LVL_W     = 4;
    localparam int COORD_W   = 9;
    localparam int IDX_W     = 16;
    localparam int FRAC_BITS = 8;

    localparam logic [1:0] PH_VERT  = 2'd0;
    localparam logic [1:0] PH_TRI_A = 2'd1;
    localparam logic [1:0] PH_TRI_B = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic KIND_VERT = 1'b0;
    localparam logic KIND_TRI  = 1'b1;

    typedef struct packed {
        logic               item_kind;
        logic [COORD_W-1:0] coord_u;
        logic [COORD_W-1:0] coord_v;
        logic [IDX_W-1:0]   index_a;
        logic [IDX_W-1:0]   index_b;
        logic [IDX_W-1:0]   index_c;
        logic               last;
    } t_result;

endpackage

`default_nettype wire

/* rtl/tgt_seq.sv */
// Patch sequencer: grid counters, row bases and the word computed per step.
`timescale 1ns / 1ps
`default_nettype none

module tgt_seq import tgt_pkg::*; #(
    parameter int MAX_LEVEL = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [LVL_W-1:0] i_cfg_data,
    input  wire logic             i_step,
    input  wire logic             i_restart,
    output logic                  o_res_valid,
    output t_result               o_res
);

    localparam int CW = MAX_LEVEL + 1;

    logic [LVL_W-1:0] r_cfg_level;
    logic [LVL_W-1:0] r_level, n_level;
    logic [CW-1:0]    r_row, n_row;
    logic [CW-1:0]    r_col, n_col;
    logic [1:0]       r_phase, n_phase;
    logic [IDX_W-1:0] r_row_base, n_row_base;
    logic [IDX_W-1:0] r_next_base, n_next_base;

    logic [LVL_W-1:0] e_level;
    logic [CW-1:0]    e_row, e_col;
    logic [1:0]       e_phase;
    logic [IDX_W-1:0] e_rb, e_nrb;

    logic [CW-1:0]    seg_cnt, rem, col_inc, row_inc, base_step;
    logic [LVL_W-1:0] shift;
    logic             cell_end, patch_end;

    always_comb begin
        if (i_restart) begin
            e_level = (r_cfg_level > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : r_cfg_level;
            e_row   = '0;
            e_col   = '0;
            e_phase = PH_VERT;
            e_rb    = '0;
            e_nrb   = '0;
        end else begin
            e_level = r_level;
            e_row   = r_row;
            e_col   = r_col;
            e_phase = r_phase;
            e_rb    = r_row_base;
            e_nrb   = r_next_base;
        end
    end

    assign seg_cnt   = CW'(1) << e_level;
    assign rem       = seg_cnt - e_row;
    assign col_inc   = e_col + CW'(1);
    assign row_inc   = e_row + CW'(1);
    assign base_step = seg_cnt - row_inc + CW'(1);
    assign shift     = LVL_W'(FRAC_BITS) - e_level;
    assign cell_end  = (col_inc >= rem);
    assign patch_end = (row_inc >= seg_cnt);

    always_comb begin
        n_level     = e_level;
        n_row       = e_row;
        n_col       = e_col;
        n_phase     = e_phase;
        n_row_base  = e_rb;
        n_next_base = e_nrb;
        o_res       = '0;
        o_res_valid = (e_phase != PH_DONE);

        unique case (e_phase)
            PH_VERT: begin
                o_res.item_kind = KIND_VERT;
                o_res.coord_u   = COORD_W'(e_row) << shift;
                o_res.coord_v   = COORD_W'(e_col) << shift;
                if (e_col < rem) begin
                    n_col = col_inc;
                end else begin
                    n_row = row_inc;
                    n_col = '0;
                    if (row_inc > seg_cnt) begin
                        n_row       = '0;
                        n_row_base  = '0;
                        n_next_base = IDX_W'(seg_cnt) + IDX_W'(1);
                        n_phase     = PH_TRI_A;
                    end
                end
            end
            PH_TRI_A, PH_TRI_B: begin
                o_res.item_kind = KIND_TRI;
                if (e_phase == PH_TRI_A) begin
                    o_res.index_a = e_rb + IDX_W'(e_col);
                    o_res.index_b = e_nrb + IDX_W'(e_col);
                    o_res.index_c = e_rb + IDX_W'(col_inc);
                end else begin
                    o_res.index_a = e_nrb + IDX_W'(e_col);
                    o_res.index_b = e_nrb + IDX_W'(col_inc);
                    o_res.index_c = e_rb + IDX_W'(col_inc);
                end
                if (e_phase == PH_TRI_A && !cell_end) begin
                    n_phase = PH_TRI_B;
                end else if (cell_end) begin
                    n_row = row_inc;
                    n_col = '0;
                    if (patch_end) begin
                        n_phase    = PH_DONE;
                        o_res.last = 1'b1;
                    end else begin
                        n_row_base  = e_nrb;
                        n_next_base = e_nrb + IDX_W'(base_step);
                        n_phase     = PH_TRI_A;
                    end
                end else begin
                    n_col   = col_inc;
                    n_phase = PH_TRI_A;
                end
            end
            PH_DONE: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_level <= '0;
            r_level     <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_phase     <= PH_DONE;
            r_row_base  <= '0;
            r_next_base <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_level <= i_cfg_data;
            end
            if (i_step) begin
                r_level     <= n_level;
                r_row       <= n_row;
                r_col       <= n_col;
                r_phase     <= n_phase;
                r_row_base  <= n_row_base;
                r_next_base <= n_next_base;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/tgt_out_reg.sv */
// Output register stage for result words, with flow control towards the input side.
`timescale 1ns / 1ps
`default_nettype none

module tgt_out_reg import tgt_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire logic    i_res_valid,
    input  wire t_result i_res,
    input  wire logic    i_out_ready,
    output logic         o_can_load,
    output logic         o_out_valid,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_can_load  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

/* rtl/triangle_grid_tessellator_top.sv */
// Top level of the uniform triangle grid tessellator.
// A result word is registered and is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while input ready is high; the sequencer updates all counters in one step.
// Input ready drops only while a result word is held and not taken downstream.
// Reset (synchronous, active low) clears the level and leaves the patch finished:
// no result is produced until a word with restart set is accepted.
`timescale 1ns / 1ps
`default_nettype none

module triangle_grid_tessellator_top import tgt_pkg::*; #(
    parameter int MAX_LEVEL = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [LVL_W-1:0]   i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_restart,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_item_kind,
    output logic [COORD_W-1:0]      o_coord_u,
    output logic [COORD_W-1:0]      o_coord_v,
    output logic [IDX_W-1:0]        o_index_a,
    output logic [IDX_W-1:0]        o_index_b,
    output logic [IDX_W-1:0]        o_index_c,
    output logic                    o_last
);

    logic    step;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign step = i_in_valid && o_in_ready;

    tgt_seq #(
        .MAX_LEVEL(MAX_LEVEL)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .i_restart   (i_restart),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    tgt_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_can_load  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    assign o_item_kind = out_res.item_kind;
    assign o_coord_u   = out_res.coord_u;
    assign o_coord_v   = out_res.coord_v;
    assign o_index_a   = out_res.index_a;
    assign o_index_b   = out_res.index_b;
    assign o_index_c   = out_res.index_c;
    assign o_last      = out_res.last;

endmodule

`default_nettype wire

/* rtl/tgt_checker.sv */
// Port-level checks for the tessellator top level, bound into it.
`timescale 1ns / 1ps
`default_nettype none

module tgt_checker import tgt_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic               o_item_kind,
    input wire logic [IDX_W-1:0]   o_index_a,
    input wire logic [IDX_W-1:0]   o_index_b,
    input wire logic [IDX_W-1:0]   o_index_c,
    input wire logic               o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    a_last_is_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_item_kind == KIND_TRI)
        else $error("last flag on a vertex word");

    a_vert_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_item_kind == KIND_VERT |->
            o_index_a == '0 && o_index_b == '0 && o_index_c == '0)
        else $error("vertex word carries indices");

    a_no_word_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result word present straight after reset");

endmodule

bind triangle_grid_tessellator_top tgt_checker u_tgt_checker (.*);

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the triangle grid tessellator: predicted vertex and triangle words.
`timescale 1ns / 1ps

module tb_top;
    import tgt_pkg::*;

    localparam int PERIOD       = 8;
    localparam int MAX_LEVEL    = 8;
    localparam int RANDOM_WORDS = 250;
    localparam int LARGE_WORDS  = 300;
    localparam int SETTLE       = 3;
    localparam int END_WAIT     = 5000;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PRINT_CAP    = 40;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_cfg_we   = 1'b0;
    logic [LVL_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               i_restart  = 1'b0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_item_kind;
    logic [COORD_W-1:0] o_coord_u;
    logic [COORD_W-1:0] o_coord_v;
    logic [IDX_W-1:0]   o_index_a;
    logic [IDX_W-1:0]   o_index_b;
    logic [IDX_W-1:0]   o_index_c;
    logic               o_last;

    triangle_grid_tessellator_top #(.MAX_LEVEL(MAX_LEVEL)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_item_kind (o_item_kind),
        .o_coord_u   (o_coord_u),
        .o_coord_v   (o_coord_v),
        .o_index_a   (o_index_a),
        .o_index_b   (o_index_b),
        .o_index_c   (o_index_c),
        .o_last      (o_last)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    // Tessellator state as predicted
    logic [LVL_W-1:0] level_reg  = '0;
    logic [LVL_W-1:0] level_act  = '0;
    logic [8:0]       row_cnt    = '0;
    logic [8:0]       col_cnt    = '0;
    logic [1:0]       gen_phase  = PH_DONE;
    logic [IDX_W-1:0] row_start  = '0;
    logic [IDX_W-1:0] next_start = '0;

    t_result expected_words[$];
    int      errors     = 0;
    int      emitted    = 0;
    int      cycles     = 0;
    int      out_stall  = 0;
    bit      in_idle    = 1'b1;
    bit      out_idle   = 1'b1;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < PRINT_CAP)
            $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
        errors++;
    endtask

    function automatic int gap_len(input bit on);
        int r;
        if (!on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Step to the next cell; high when the patch has just ended
    function automatic bit advance_cell(input int n);
        col_cnt++;
        if (int'(col_cnt) >= n - int'(row_cnt)) begin
            row_cnt++;
            col_cnt = '0;
            if (int'(row_cnt) >= n) begin
                gen_phase = PH_DONE;
                return 1'b1;
            end
            row_start  = next_start;
            next_start = IDX_W'(int'(next_start) + n - int'(row_cnt) + 1);
        end
        gen_phase = PH_TRI_A;
        return 1'b0;
    endfunction

    function automatic bit next_patch_word(input logic rs, output t_result w);
        int n;
        int sh;
        w = '0;
        if (rs) begin
            level_act  = (level_reg > MAX_LEVEL) ? LVL_W'(MAX_LEVEL) : level_reg;
            row_cnt    = '0;
            col_cnt    = '0;
            row_start  = '0;
            next_start = '0;
            gen_phase  = PH_VERT;
        end
        if (gen_phase == PH_DONE) return 1'b0;
        n  = 1 << level_act;
        sh = FRAC_BITS - int'(level_act);
        if (gen_phase == PH_VERT) begin
            w.item_kind = KIND_VERT;
            w.coord_u   = COORD_W'(int'(row_cnt) << sh);
            w.coord_v   = COORD_W'(int'(col_cnt) << sh);
            if (int'(col_cnt) < n - int'(row_cnt)) begin
                col_cnt++;
            end else begin
                row_cnt++;
                col_cnt = '0;
                if (int'(row_cnt) > n) begin
                    row_cnt    = '0;
                    row_start  = '0;
                    next_start = IDX_W'(n + 1);
                    gen_phase  = PH_TRI_A;
                end
            end
            return 1'b1;
        end
        w.item_kind = KIND_TRI;
        if (gen_phase == PH_TRI_A) begin
            w.index_a = row_start + col_cnt;
            w.index_b = next_start + col_cnt;
            w.index_c = row_start + col_cnt + 1'b1;
            if (int'(col_cnt) + 1 < n - int'(row_cnt))
                gen_phase = PH_TRI_B;
            else
                w.last = advance_cell(n);
        end else begin
            w.index_a = next_start + col_cnt;
            w.index_b = next_start + col_cnt + 1'b1;
            w.index_c = row_start + col_cnt + 1'b1;
            w.last    = advance_cell(n);
        end
        return 1'b1;
    endfunction

    task automatic send_word(input logic rs);
        int      gap;
        t_result w;
        gap = gap_len(in_idle);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= rs;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        if (next_patch_word(rs, w)) begin
            expected_words.insert(expected_words.size(), w);
            emitted++;
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_level(input logic [LVL_W-1:0] lvl);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= lvl;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        level_reg = lvl;
    endtask

    // Words after reset give nothing until a restart
    task automatic test_idle_after_reset();
        repeat (3) send_word(1'b0);
    endtask

    // Reset level 0: one triangle, then ticks past the end
    task automatic test_smallest_patch();
        send_word(1'b1);
        while (gen_phase != PH_DONE) send_word(1'b0);
        repeat (2) send_word(1'b0);
    endtask

    // New level written mid-patch must wait for the next restart
    task automatic test_level_change_mid_patch();
        set_level(LVL_W'(1));
        send_word(1'b1);
        repeat (3) send_word(1'b0);
        set_level(LVL_W'(0));
        while (gen_phase != PH_DONE) send_word(1'b0);
        send_word(1'b0);
    endtask

    // Levels above range saturate; also restart while a patch is running
    task automatic test_level_saturation();
        set_level(LVL_W'(15));
        send_word(1'b1);
        repeat (3) send_word(1'b0);
        set_level(LVL_W'(9));
        send_word(1'b1);
        repeat (2) send_word(1'b0);
    endtask

    // Top level, back to back: the long first row and the turn into the second
    task automatic test_largest_patch();
        in_idle  = 1'b0;
        out_idle = 1'b0;
        set_level(LVL_W'(MAX_LEVEL));
        send_word(1'b1);
        repeat (LARGE_WORDS) send_word(1'b0);
    endtask

    task automatic test_random_patches();
        int start;
        int r;
        int lvl;
        int k;
        start = emitted;
        while (emitted - start < RANDOM_WORDS) begin
            in_idle  = ($urandom_range(0, 3) != 0);
            out_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 7) begin
                r = $urandom_range(0, 99);
                if (r < 75)      lvl = $urandom_range(0, 3);
                else if (r < 90) lvl = 4;
                else             lvl = $urandom_range(5, 15);
                set_level(LVL_W'(lvl));
            end
            send_word(1'b1);
            if (level_act <= 3 && $urandom_range(0, 3) != 0) begin
                while (gen_phase != PH_DONE) send_word(1'b0);
            end else begin
                k = $urandom_range(0, 40);
                repeat (k) send_word(1'b0);
            end
            k = $urandom_range(0, 2);
            repeat (k) send_word(1'b0);
        end
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        int      stall;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = expected_words.pop_front();
                if (o_item_kind !== want.item_kind)
                    report_mismatch("item_kind", o_item_kind, want.item_kind);
                if (o_coord_u !== want.coord_u)
                    report_mismatch("coord_u", o_coord_u, want.coord_u);
                if (o_coord_v !== want.coord_v)
                    report_mismatch("coord_v", o_coord_v, want.coord_v);
                if (o_index_a !== want.index_a)
                    report_mismatch("index_a", o_index_a, want.index_a);
                if (o_index_b !== want.index_b)
                    report_mismatch("index_b", o_index_b, want.index_b);
                if (o_index_c !== want.index_c)
                    report_mismatch("index_c", o_index_c, want.index_c);
                if (o_last !== want.last)
                    report_mismatch("last", o_last, want.last);
            end
        end
        if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else begin
            stall = gap_len(out_idle);
            if (stall > 0) begin
                out_stall = stall - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_after_reset();
        test_smallest_patch();
        test_level_change_mid_patch();
        test_level_saturation();
        test_largest_patch();
        test_random_patches();
        i_in_valid <= 1'b0;
        for (k = 0; k < END_WAIT && expected_words.size() != 0; k++) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (expected_words.size() != 0)
            report_mismatch("words never produced", 0, expected_words.size());
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
